[src/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types and codes shared by the fixed block pool allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Operation codes on the input word
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_REINIT  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_RELEASED = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;
  localparam logic [2:0] ST_REINIT   = 3'd5;

  // Register indexes (selected by paddr[2])
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Register reset values
  localparam logic [7:0] BLOCK_SIZE_RST  = 8'd16;
  localparam logic [8:0] BLOCK_COUNT_RST = 9'd256;

  typedef struct packed {
    logic [8:0] block_count;
    logic [7:0] block_size;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  blocks_free;
    logic [15:0] byte_offset;
    logic [7:0]  granted_index;
    logic [2:0]  status;
  } res_t;

endpackage

[src/fbpa_ram.sv]
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/fbpa_regs.sv]
// ----------------------------------------------------------------------------
// fbpa_regs
// APB register file holding block_size and block_count.
// ----------------------------------------------------------------------------
module fbpa_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output fbpa_pkg::cfg_t    cfg
);
  import fbpa_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size  <= BLOCK_SIZE_RST;
      cfg.block_count <= BLOCK_COUNT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_BLOCK_SIZE:  cfg.block_size  <= pwdata[7:0];
        REG_BLOCK_COUNT: cfg.block_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_SIZE:  prdata = {24'd0, cfg.block_size};
      REG_BLOCK_COUNT: prdata = {23'd0, cfg.block_count};
      default:         prdata = 32'd0;
    endcase
  end

  // Low address bits carry no register select
  logic unused_addr;
  assign unused_addr = ^{paddr[1:0], pwdata[31:9]};

endmodule

[src/fbpa_ctrl.sv]
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Free list control: head, counters and the link table RAM.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  fbpa_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_index,
  output logic              res_valid,
  input  logic              res_ready,
  output fbpa_pkg::res_t    res
);
  import fbpa_pkg::*;

  localparam int         DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int         AW    = $clog2(DEPTH);
  localparam logic [8:0] CAP   = 9'(DEPTH);

  logic          head_valid, head_valid_next;
  logic [AW-1:0] head, head_next;
  logic [8:0]    next_untouched, next_untouched_next;
  logic [8:0]    free_total, free_total_next;
  logic [8:0]    eff, eff_next;
  logic          pop_pending, pop_pending_next;

  logic          accept;
  logic [8:0]    untouched, freed_len, cfg_eff;
  logic          link_we;
  logic [7:0]    link_wdata, link_rdata;
  logic [7:0]    grant;
  logic [2:0]    status;

  assign in_ready = !pop_pending && (!res_valid || res_ready);
  assign accept   = in_valid && in_ready;

  assign cfg_eff   = (cfg.block_count > CAP) ? CAP : cfg.block_count;
  assign untouched = (next_untouched < eff) ? (eff - next_untouched) : 9'd0;
  assign freed_len = (free_total > untouched) ? (free_total - untouched) : 9'd0;

  // Read the link of the head every cycle; it is consumed after a pop
  fbpa_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (in_index[AW-1:0]),
    .wdata (link_wdata),
    .raddr (head),
    .rdata (link_rdata)
  );

  always_comb begin
    head_valid_next     = head_valid;
    head_next           = head;
    next_untouched_next = next_untouched;
    free_total_next     = free_total;
    eff_next            = eff;
    pop_pending_next    = 1'b0;
    link_we             = 1'b0;
    link_wdata          = head_valid ? 8'(head) : 8'd0;
    grant               = 8'd0;
    status              = ST_BAD;

    if (pop_pending) begin
      // Link read of the popped block lands now
      head_next = link_rdata[AW-1:0];
    end

    if (accept) begin
      unique case (in_op)
        OP_ALLOC: begin
          status = ST_EMPTY;
          if (free_total != 9'd0) begin
            if (head_valid && freed_len != 9'd0) begin
              grant            = 8'(head);
              head_valid_next  = (freed_len > 9'd1);
              pop_pending_next = (freed_len > 9'd1);
              free_total_next  = free_total - 9'd1;
              status           = ST_ALLOC;
            end else if (next_untouched < eff) begin
              grant               = next_untouched[7:0];
              next_untouched_next = next_untouched + 9'd1;
              free_total_next     = free_total - 9'd1;
              status              = ST_ALLOC;
            end
          end
        end
        OP_RELEASE: begin
          if ({1'b0, in_index} >= eff) begin
            status = ST_BAD;
          end else if (free_total >= eff) begin
            status = ST_FULL;
          end else begin
            link_we         = 1'b1;
            head_next       = in_index[AW-1:0];
            head_valid_next = 1'b1;
            free_total_next = free_total + 9'd1;
            status          = ST_RELEASED;
          end
        end
        OP_REINIT: begin
          eff_next            = cfg_eff;
          head_valid_next     = 1'b0;
          next_untouched_next = 9'd0;
          free_total_next     = cfg_eff;
          status              = ST_REINIT;
        end
        default: status = ST_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid     <= 1'b0;
      next_untouched <= 9'd0;
      free_total     <= CAP;
      eff            <= CAP;
      pop_pending    <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      head_valid     <= head_valid_next;
      next_untouched <= next_untouched_next;
      free_total     <= free_total_next;
      eff            <= eff_next;
      pop_pending    <= pop_pending_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    if (accept) begin
      res.status        <= status;
      res.granted_index <= grant;
      res.byte_offset   <= (status == ST_ALLOC) ?
                           16'(16'(grant) * 16'(cfg.block_size)) : 16'd0;
      res.blocks_free   <= free_total_next;
    end
  end

endmodule

[src/fixed_block_pool_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size block pool kept as a LIFO free list with an external link table.
// ----------------------------------------------------------------------------
//
//   channel  | direction | fields (tdata, lowest bit first)
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | op[1:0], block_index[9:2], zero pad [15:10]
//   m_axis   | out       | status[2:0], granted_index[10:3], byte_offset[26:11],
//            |           | blocks_free[35:27], zero pad [39:36]
//   APB      | cfg       | 0x0 block_size, 0x4 block_count
//
// An allocate that pops a freed block with more freed blocks behind it holds
// s_axis until the link of the popped block comes out of the registered-read
// link table RAM. Every other word, a pop of the last freed block included,
// leaves s_axis ready for the next word. The result shows on m_axis the
// cycle after its word is accepted, and a new word is taken while that
// result waits if the output register is drained in the same cycle.
// Reset is synchronous; the link table needs no clearing pass, so words are
// taken from the first cycle after reset. A stall on m_axis holds s_axis.
// block_count takes effect at reset or at a reinitialise word only.
//
module fixed_block_pool_allocator_unit #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], block_index[9:2]
  // Result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status, granted_index, byte_offset, blocks_free
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbpa_pkg::*;

  cfg_t cfg;
  res_t res;

  fbpa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbpa_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tdata[1:0]),
    .in_index  (s_axis_tdata[9:2]),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // Pack fields from the lowest bit up, pad to whole bytes
  assign m_axis_tdata = {4'd0, res.blocks_free, res.byte_offset,
                         res.granted_index, res.status};

  // Upper input pad bits carry nothing
  logic unused_pad;
  assign unused_pad = ^s_axis_tdata[15:10];

endmodule

[src/fbpa_checker.sv]
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        pready
);
  import fbpa_pkg::*;

  // Every accepted word yields a result word the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word gave no result");

  // Only a granted block carries an index and an offset
  a_grant_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:0] != ST_ALLOC) |->
      (m_axis_tdata[10:3] == 8'd0) && (m_axis_tdata[26:11] == 16'd0))
    else $error("non-grant result carries index or offset");

  // Free count never exceeds the largest pool of 256 blocks
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[35:27] <= 9'd256))
    else $error("free count out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
